// ----- rtl/ple_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_MV,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_MV,
        S_SRCH_CHK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage : ple_pkg
`default_nettype wire

// ----- rtl/ple_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : ple_ram
`default_nettype wire

// ----- rtl/positional_list_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_*      | in  | position[8:0], value[40:9], zero pad     | kind[1:0]
//  m_*      | out | status[1:0], found_position[10:2],       | -
//           |     | entry_count[19:11], zero pad             |
//
//  one item at a time; s_tready is high only while the sequencer is idle
//  insert moves entries from position on up a slot (check, read, move), then writes;
//  delete moves later entries down a slot; search compares entries in order to a match
//  reset clears the count and control state; ram contents need no clearing
//  a finished result waits in the output register; the sequencer stalls in its
//  response state while that register is still full
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ple_pkg::IN_DATA_W-1:0]     s_tdata,  // position, value
    input  wire logic [ple_pkg::IN_USER_W-1:0]     s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ple_pkg::OUT_DATA_W-1:0]    m_tdata   // status, found_position, entry_count
);

    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        count_reg, count_next;
    status_t              status_reg, status_next;
    logic [POS_W-1:0]     found_reg, found_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VAL_W-1:0]     ram_wdata, ram_rdata;

    kind_t                in_kind;
    logic [POS_W-1:0]     in_pos;
    logic [PW-1:0]        in_pos_x, count_x, k_x, pos_x;
    logic                 accept, out_free;

    assign in_kind  = kind_t'(s_tuser);
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_pos_x = PW'(in_pos);
    assign pos_x    = PW'(pos_reg);
    assign count_x  = PW'(count_reg);
    assign k_x      = PW'(k_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_INSERT:
                        begin
                            if (in_pos_x == '0 || in_pos_x > count_x + PW'(1)
                                || count_x == PW'(CAPACITY))
                                state_next = S_RESP;
                            else
                                state_next = S_INS_CHK;
                        end
                        KIND_DELETE:
                        begin
                            if (in_pos_x == '0 || in_pos_x > count_x)
                                state_next = S_RESP;
                            else
                                state_next = S_DEL_CHK;
                        end
                        KIND_SEARCH: state_next = S_SRCH_CHK;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_INS_CHK:  state_next = (k_x >= pos_x) ? S_INS_RD : S_INS_WR;
            S_INS_RD:   state_next = S_INS_MV;
            S_INS_MV:   state_next = S_INS_CHK;
            S_INS_WR:   state_next = S_RESP;
            S_DEL_CHK:  state_next = (k_x + PW'(1) < count_x) ? S_DEL_RD : S_RESP;
            S_DEL_RD:   state_next = S_DEL_MV;
            S_DEL_MV:   state_next = S_DEL_CHK;
            S_SRCH_CHK: state_next = (k_reg < count_reg) ? S_SRCH_RD : S_RESP;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP: state_next = (ram_rdata == val_reg) ? S_RESP : S_SRCH_CHK;
            S_RESP:     state_next = out_free ? S_IDLE : S_RESP;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pos_next      = pos_reg;
        val_next      = val_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = k_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = k_reg[AW-1:0];

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = in_pos;
                    val_next    = s_tdata[POS_W +: VAL_W];
                    found_next  = '0;
                    status_next = ST_MISS;
                    case (in_kind)
                        KIND_INSERT:
                        begin
                            k_next = count_reg;
                            if (!(in_pos_x == '0 || in_pos_x > count_x + PW'(1))
                                && count_x == PW'(CAPACITY))
                                status_next = ST_FULL;
                        end
                        KIND_DELETE: k_next = CW'(in_pos_x - PW'(1));
                        KIND_SEARCH: k_next = '0;
                        default:     k_next = k_reg;
                    endcase
                end
            end
            S_INS_CHK: ;
            S_INS_RD:
            begin
                ram_raddr = AW'(k_reg - CW'(1));
            end
            S_INS_MV:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AW-1:0];
                k_next    = k_reg - CW'(1);
            end
            S_INS_WR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = AW'(pos_x - PW'(1));
                ram_wdata   = val_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
            end
            S_DEL_CHK:
            begin
                if (!(k_x + PW'(1) < count_x))
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                end
            end
            S_DEL_RD:
            begin
                ram_raddr = AW'(k_x + PW'(1));
            end
            S_DEL_MV:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AW-1:0];
                k_next    = k_reg + CW'(1);
            end
            S_SRCH_CHK: ;
            S_SRCH_RD: ;
            S_SRCH_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    status_next = ST_OK;
                    found_next  = POS_W'(k_x + PW'(1));
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_W'({POS_W'(count_reg), found_reg, status_reg});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        k_reg       <= k_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule : positional_list_engine_core
`default_nettype wire

// ----- rtl/ple_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ple_pkg::OUT_DATA_W-1:0] m_tdata
);

    import ple_pkg::*;

    // one item in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[STAT_W-1:0] != ST_RSVD)
        else $error("reserved status code");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[STAT_W-1:0] != ST_OK |-> m_tdata[STAT_W +: POS_W] == '0)
        else $error("found_position set on a failed item");

endmodule : ple_checker

bind positional_list_engine_core ple_checker u_ple_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete and search items into the positional list engine and
// checks every result against a table or a queue-based shadow list. A directed
// table covers the empty list, the value extremes, bad positions, duplicates
// and the unknown kind. A random part follows that fills the list to capacity,
// hits the full case and drains it again, with bursty input and a stalling
// output side.
// ----------------------------------------------------------------------------
module testbench;
    import ple_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int PAD_W        = IN_DATA_W - POS_W - VAL_W;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   found;
        logic [POS_W-1:0]   count;
    } list_result_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   value;
        logic               typed;
        list_result_t       want;
    } list_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;   // position, value
    logic [IN_USER_W-1:0]   s_tuser = '0;   // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;        // status, found_position, entry_count

    logic [VAL_W-1:0]       shadow_list[$];
    list_result_t           pending_results[$];
    int                     mismatches = 0;
    int                     cycles = 0;
    int                     burst_left = 0;
    int                     rx_run = 0;

    list_op_t directed_ops [25] = '{
        '{KIND_SEARCH, 9'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd0}},
        '{KIND_DELETE, 9'd1,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd0}},
        '{KIND_INSERT, 9'd0,   32'h1234_5678, 1'b1, '{ST_MISS, 9'd0, 9'd0}},
        '{KIND_INSERT, 9'd2,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd0}},
        '{KIND_INSERT, 9'd1,   32'h8000_0000, 1'b1, '{ST_OK,   9'd0, 9'd1}},
        '{KIND_INSERT, 9'd2,   32'h7FFF_FFFF, 1'b1, '{ST_OK,   9'd0, 9'd2}},
        '{KIND_INSERT, 9'd1,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   9'd0, 9'd3}},
        '{KIND_INSERT, 9'd511, 32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd3}},
        '{KIND_SEARCH, 9'd0,   32'h7FFF_FFFF, 1'b1, '{ST_OK,   9'd3, 9'd3}},
        '{KIND_SEARCH, 9'd0,   32'h8000_0000, 1'b1, '{ST_OK,   9'd2, 9'd3}},
        '{KIND_SEARCH, 9'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   9'd1, 9'd3}},
        '{KIND_SEARCH, 9'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd3}},
        '{KIND_NONE,   9'd1,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd3}},
        '{KIND_NONE,   9'd511, 32'hFFFF_FFFF, 1'b1, '{ST_MISS, 9'd0, 9'd3}},
        '{KIND_INSERT, 9'd4,   32'h0000_0001, 1'b1, '{ST_OK,   9'd0, 9'd4}},
        '{KIND_INSERT, 9'd3,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   9'd0, 9'd5}},
        '{KIND_SEARCH, 9'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   9'd1, 9'd5}},
        '{KIND_DELETE, 9'd6,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd5}},
        '{KIND_DELETE, 9'd0,   32'h0000_0000, 1'b1, '{ST_MISS, 9'd0, 9'd5}},
        '{KIND_DELETE, 9'd1,   32'h0000_0000, 1'b1, '{ST_OK,   9'd0, 9'd4}},
        '{KIND_SEARCH, 9'd0,   32'hFFFF_FFFF, 1'b1, '{ST_OK,   9'd2, 9'd4}},
        '{KIND_DELETE, 9'd4,   32'h0000_0000, 1'b1, '{ST_OK,   9'd0, 9'd3}},
        '{KIND_INSERT, 9'd2,   32'hAAAA_AAAA, 1'b0, '{ST_OK,   9'd0, 9'd0}},
        '{KIND_SEARCH, 9'd0,   32'hAAAA_AAAA, 1'b0, '{ST_OK,   9'd0, 9'd0}},
        '{KIND_DELETE, 9'd2,   32'h0000_0000, 1'b0, '{ST_OK,   9'd0, 9'd0}}
    };

    always #6 clk = ~clk;

    positional_list_engine_core #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic list_result_t apply_list_op(kind_t kind, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] value);
        list_result_t r;
        int           n;
        n = shadow_list.size();
        r.status = ST_MISS;
        r.found  = '0;
        case (kind)
            KIND_INSERT:
            begin
                if (pos >= 1 && pos <= n + 1)
                begin
                    if (n >= LIST_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        shadow_list.insert(int'(pos) - 1, value);
                        r.status = ST_OK;
                    end
                end
            end
            KIND_DELETE:
            begin
                if (pos >= 1 && pos <= n)
                begin
                    shadow_list.delete(int'(pos) - 1);
                    r.status = ST_OK;
                end
            end
            KIND_SEARCH:
            begin
                for (int k = 0; k < n; k++)
                begin
                    if (shadow_list[k] == value)
                    begin
                        r.status = ST_OK;
                        r.found  = POS_W'(k + 1);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = POS_W'(shadow_list.size());
        return r;
    endfunction

    task automatic send_op(kind_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value,
                           logic typed, list_result_t want);
        list_result_t predicted;
        int           gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_W{1'b0}}, value, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_list_op(kind, pos, value);
        pending_results.push_back(typed ? want : predicted);
        burst_left--;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // output side stalls in runs of random length
    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_run = $urandom_range(1, 20);
            m_tready <= ($urandom_range(0, 3) != 0);
        end
        rx_run--;
    end

    always @(posedge clk)
    begin
        list_result_t seen;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.status = status_t'(m_tdata[1:0]);
            seen.found  = m_tdata[10:2];
            seen.count  = m_tdata[19:11];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d found %0d count %0d",
                             seen.status, seen.found, seen.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.found, want.count,
                                 seen.status, seen.found, seen.count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic             filling;
        int               full_items;
        int               n;
        int               roll;
        kind_t            kind;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[i])
            send_op(directed_ops[i].kind, directed_ops[i].pos, directed_ops[i].value,
                    directed_ops[i].typed, directed_ops[i].want);

        hold_until_drained();

        // fill toward capacity, probe the full list, then drain, and repeat
        filling    = 1'b1;
        full_items = 0;
        repeat (RANDOM_ITEMS)
        begin
            n = shadow_list.size();
            if (!filling && n == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (filling && n == LIST_DEPTH)
            begin
                kind = KIND_INSERT;
                pos  = (roll < 50) ? POS_W'($urandom_range(1, n + 1))
                                   : POS_W'($urandom_range(0, 511));
                full_items++;
                if (full_items >= 6)
                begin
                    filling    = 1'b0;
                    full_items = 0;
                end
            end
            else if (roll < 8)
            begin
                kind = kind_t'($urandom_range(0, 3));
                pos  = POS_W'($urandom_range(0, 511));
            end
            else if (roll < 20)
            begin
                kind = KIND_SEARCH;
                pos  = POS_W'($urandom_range(0, 511));
            end
            else if (roll < (filling ? 94 : 24))
            begin
                kind = KIND_INSERT;
                pos  = POS_W'($urandom_range(1, n + 1));
            end
            else
            begin
                kind = KIND_DELETE;
                pos  = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
            end

            if (kind == KIND_SEARCH && n > 0 && $urandom_range(0, 2) != 0)
                value = shadow_list[$urandom_range(0, n - 1)];
            else
            begin
                case ($urandom_range(0, 7))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    3, 4:    value = $urandom_range(0, 8) - 4;
                    default: value = $urandom;
                endcase
            end

            send_op(kind, pos, value, 1'b0, '0);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
